>>> design/per_client_delay_tracker_core_macros.svh
// Assertion macros for the per-client delay tracker
`ifndef PER_CLIENT_DELAY_TRACKER_CORE_MACROS_SVH
`define PER_CLIENT_DELAY_TRACKER_CORE_MACROS_SVH
`ifndef SYNTH
`define PCDT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PCDT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PCDT_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define PCDT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> design/pcdt_pkg.sv
// Shared types and constants of the per-client delay tracker
package pcdt_pkg;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned FracW  = 12;
  localparam int unsigned DelayW = 31;
  localparam int unsigned CntW   = 32;
  localparam int unsigned CfgW   = 16;
  localparam logic [31:0] HashMul = 32'h9E37_79B1;

  typedef enum logic [0:0] {
    CFG_PENALTY  = 1'b0,
    CFG_RECOVERY = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    MODE_ACCESS = 1'b0,
    MODE_SET    = 1'b1
  } mode_e;

  typedef struct packed {
    logic [0:0]        mode;
    logic [AddrW-1:0]  client_addr;
    logic [TimeW-1:0]  now_seconds;
    logic [FracW-1:0]  penalty_fraction;
    logic [DelayW-1:0] set_delay_ms;
  } req_t;

  typedef struct packed {
    logic [DelayW-1:0] delay_ms;
    logic [CntW-1:0]   hit_count;
    logic [DelayW-1:0] peak_delay_ms;
    logic              table_full;
  } rsp_t;

  // Record held in the table memory (address, last seen, signed delay, peak, hits)
  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [TimeW-1:0]  last;
    logic [31:0]       delay;
    logic [DelayW-1:0] peak;
    logic [CntW-1:0]   hits;
  } rec_t;

  function automatic logic [31:0] hash32(input logic [31:0] a);
    logic [31:0] h;
    h = a * HashMul;
    return h ^ (h >> 16);
  endfunction
endpackage

>>> design/pcdt_if.sv
// Valid/ready channel carrying one transaction payload
interface pcdt_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/per_client_delay_tracker_core.sv
// Per-client delay tracker: hashed set-associative client table with leaky-bucket delay.
// One request at a time. An access runs from acceptance through hashing, then the ways of
// the hashed set are read one per cycle from a single-port record memory (stopping early
// when the client hits in an early way), then the delay is computed in two registered
// steps (the two products, then the sum and clamps) and the record is written back. The
// next request can be accepted in the cycle after the write, so a new request is not
// taken before the last one is through. A set-mode request takes the same probe and
// write but gives no result. Valid bits sit in flip-flops cleared by reset, so no clearing
// pass is needed. Request ready depends only on the state: the result register holds a
// reply until it is taken while the table is already probing the next request, and a
// request that needs the result register while it is still occupied waits in its last step.
module per_client_delay_tracker_core #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned TABLE_WAYS    = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  pcdt_if.sink                 req,
  pcdt_if.source               rsp
);
  import pcdt_pkg::*;
  `include "per_client_delay_tracker_core_macros.svh"

  localparam int unsigned WaysUsed = (TABLE_WAYS < TABLE_ENTRIES) ? TABLE_WAYS : TABLE_ENTRIES;
  localparam int unsigned NumSets  = (TABLE_ENTRIES / WaysUsed) > 0 ?
                                     (TABLE_ENTRIES / WaysUsed) : 1;
  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned WayW = (WaysUsed > 1) ? $clog2(WaysUsed) : 1;
  localparam int unsigned RecW = $bits(rec_t);

  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_PROBE, S_MATH1, S_MATH2, S_WRITE
  } state_e;

  // Configuration registers
  logic [CfgW-1:0] pen_q, rec_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q <= 16'd75;
      rec_q <= 16'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PENALTY:  pen_q <= cfg_wdata_i;
        CFG_RECOVERY: rec_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  state_e state_q;
  req_t   r_q;
  logic [31:0] base_q;          // first entry of the set (wide for hash product)
  logic [WayW:0] way_q;         // ways issued
  logic          rd_pend_q;     // a read was issued last cycle
  logic [WayW:0] chk_q;         // way whose data is on the RAM output
  logic          hit_q, free_ok_q;
  logic [IdxW-1:0] slot_q, free_q;
  rec_t  cur_q;                 // record under update
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic signed [33:0] add_q;    // frac*pen>>8
  logic [47:0] sub_q;           // elapsed*recovery
  logic signed [49:0] dsum;
  logic [DelayW-1:0] dclamp;
  logic ovf_full;

  // Table memory
  logic ram_we;
  logic [IdxW-1:0] ram_addr;
  rec_t ram_wdata;
  logic [RecW-1:0] ram_rdata;
  rec_t rd;
  assign rd = rec_t'(ram_rdata);

  pcdt_ram #(.Width(RecW), .Depth(TABLE_ENTRIES)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  logic [IdxW-1:0] probe_idx, chk_idx;
  assign probe_idx = IdxW'(base_q + 32'(way_q));
  assign chk_idx   = IdxW'(base_q + 32'(chk_q));
  logic issue;
  assign issue = (state_q == S_PROBE) && !hit_q && (way_q < (WayW+1)'(WaysUsed))
                 && (32'(probe_idx) == base_q + 32'(way_q))
                 && (base_q + 32'(way_q) < 32'(TABLE_ENTRIES));
  logic chk_hit;
  assign chk_hit = rd_pend_q && valid_q[chk_idx] && (rd.addr == r_q.client_addr);

  assign ram_we    = (state_q == S_WRITE);
  assign ram_addr  = ram_we ? slot_q : probe_idx;
  assign ram_wdata = cur_q;

  // Delay arithmetic: elapsed clamp, sum and range clamp
  logic [31:0] gap;
  logic signed [32:0] elapsed;
  assign gap     = r_q.now_seconds - cur_q.last;
  assign elapsed = $signed({gap[31], gap});
  assign dsum = 50'(signed'(cur_q.delay)) + 50'(add_q) - $signed({2'b0, sub_q});
  assign dclamp = dsum[49] ? '0 : (|dsum[48:31]) ? '1 : dsum[30:0];
  assign ovf_full = 1'b0;

  rsp_t rsp_q;
  logic rsp_v_q;
  logic rsp_v_d;
  logic rsp_busy;
  logic probe_done;
  logic rsp_load;
  assign rsp.valid = rsp_v_q;
  assign rsp.data  = rsp_q;
  assign req.ready = (state_q == S_IDLE);

  // Result register: loaded when free or being taken in the same cycle
  assign rsp_busy   = rsp_v_q && !rsp.ready;
  assign probe_done = (state_q == S_PROBE) && !issue && !rd_pend_q;
  assign rsp_load   = !rsp_busy && (r_q.mode == MODE_ACCESS) &&
                      ((state_q == S_WRITE) || (probe_done && !hit_q && !free_ok_q));
  assign rsp_v_d    = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rsp_v_q   <= 1'b0;
      valid_q   <= '0;
      rd_pend_q <= 1'b0;
      hit_q     <= 1'b0;
      free_ok_q <= 1'b0;
      way_q     <= '0;
    end else begin
      rsp_v_q <= rsp_v_d;
      unique case (state_q)
        S_IDLE: if (req.valid && req.ready) begin
          r_q     <= req.data;
          state_q <= S_HASH;
        end
        S_HASH: begin
          base_q    <= 32'(hash32(r_q.client_addr) % NumSets) * 32'(WaysUsed);
          way_q     <= '0;
          rd_pend_q <= 1'b0;
          hit_q     <= 1'b0;
          free_ok_q <= 1'b0;
          state_q   <= S_PROBE;
        end
        S_PROBE: begin
          rd_pend_q <= issue;
          chk_q     <= way_q;
          if (issue) way_q <= way_q + (WayW+1)'(1);
          if (rd_pend_q && !hit_q) begin
            if (chk_hit) begin
              hit_q  <= 1'b1;
              slot_q <= chk_idx;
              cur_q  <= rd;
            end else if (!valid_q[chk_idx] && !free_ok_q) begin
              free_ok_q <= 1'b1;
              free_q    <= chk_idx;
            end
          end
          if (!issue && !rd_pend_q) begin
            if (hit_q) state_q <= S_MATH1;
            else if (free_ok_q) begin
              slot_q     <= free_q;
              cur_q.addr <= r_q.client_addr;
              cur_q.last <= r_q.now_seconds;
              cur_q.delay <= -32'(pen_q);
              cur_q.peak <= '0;
              cur_q.hits <= '0;
              state_q    <= S_MATH1;
            end else if (r_q.mode == MODE_SET) begin
              state_q <= S_IDLE;
            end else if (rsp_load) begin
              rsp_q   <= '{delay_ms: '0, hit_count: '0, peak_delay_ms: '0, table_full: 1'b1};
              state_q <= S_IDLE;
            end
          end
        end
        S_MATH1: begin
          add_q   <= 34'((28'(r_q.penalty_fraction) * 28'(pen_q)) >> 8);
          sub_q   <= elapsed[32] ? '0 : 48'(elapsed[31:0]) * 48'(rec_q);
          state_q <= S_MATH2;
        end
        S_MATH2: begin
          if (r_q.mode == MODE_SET) begin
            cur_q.delay <= 32'(r_q.set_delay_ms) - 32'(pen_q);
          end else begin
            cur_q.delay <= 32'(dclamp);
            if (cur_q.hits != '1) cur_q.hits <= cur_q.hits + CntW'(1);
            if (cur_q.peak < dclamp) cur_q.peak <= dclamp;
          end
          cur_q.last <= r_q.now_seconds;
          state_q    <= S_WRITE;
        end
        S_WRITE: begin
          // Access replies wait here while the result register is occupied
          valid_q[slot_q] <= 1'b1;
          if (rsp_load) begin
            rsp_q <= '{delay_ms: cur_q.delay[30:0], hit_count: cur_q.hits,
                       peak_delay_ms: cur_q.peak, table_full: ovf_full};
          end
          if (r_q.mode == MODE_SET || rsp_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `PCDT_ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, req.ready, state_q == S_IDLE)
  `PCDT_ASSERT_IMPL(a_write_slot, clk_i, rst_ni, ram_we, hit_q || free_ok_q)
  `PCDT_ASSERT_NEXT(a_write_valid, clk_i, rst_ni, ram_we, valid_q[$past(slot_q)])
  `PCDT_ASSERT_IMPL(a_no_issue_hit, clk_i, rst_ni, issue, !hit_q)
endmodule

>>> design/pcdt_ram.sv
// Generic single-port synchronous RAM with registered read
module pcdt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule
